@@ rtl/krt_pkg.sv @@
// shared types and constants for the keyed record table
package krt_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int KEY_W      = 8;
  localparam int REC_W      = 64;
  localparam int USED_W     = 5;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = ((REC_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((USED_W + REC_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_APPEND,
    S_SH_RD,
    S_SH_WR,
    S_RESULT
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [USED_W-1:0]   used_count;
    logic [REC_W-1:0]    rec;
    logic                last;
  } result_t;

endpackage

@@ rtl/krt_mem.sv @@
// record storage: one write port, one registered read port
module krt_mem #(
  parameter int TABLE_DEPTH = krt_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(TABLE_DEPTH)-1:0]      waddr,
  input  logic [krt_pkg::REC_W-1:0]           wdata,
  input  logic [$clog2(TABLE_DEPTH)-1:0]      raddr,
  output logic [krt_pkg::REC_W-1:0]           rdata
);
  import krt_pkg::*;

  logic [REC_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/krt_ctrl.sv @@
// sequencer: linear key search, append, delete compaction and key listing
module krt_ctrl #(
  parameter int TABLE_DEPTH = krt_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  krt_pkg::op_t                        in_op,
  input  logic [krt_pkg::REC_W-1:0]           in_rec,
  output logic                                res_valid,
  input  logic                                res_ready,
  output krt_pkg::result_t                    res,
  output logic                                mem_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]      mem_waddr,
  output logic [krt_pkg::REC_W-1:0]           mem_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0]      mem_raddr,
  input  logic [krt_pkg::REC_W-1:0]           mem_rdata
);
  import krt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t             state, state_next;
  op_t                op, op_next;
  logic [REC_W-1:0]   rec, rec_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [CNT_W-1:0]   count, count_next;
  status_t            res_status, res_status_next;
  logic [REC_W-1:0]   res_rec, res_rec_next;
  logic               res_last, res_last_next;

  logic [CNT_W-1:0]   idx_inc;
  logic               is_last_entry;
  logic               key_hit;

  assign idx_inc       = CNT_W'(idx) + CNT_W'(1);
  assign is_last_entry = (idx_inc == count);
  assign key_hit       = (mem_rdata[KEY_W-1:0] == rec[KEY_W-1:0]);

  assign res.status     = res_status;
  assign res.used_count = USED_W'(count);
  assign res.rec        = res_rec;
  assign res.last       = res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    rec        <= rec_next;
    idx        <= idx_next;
    res_status <= res_status_next;
    res_rec    <= res_rec_next;
    res_last   <= res_last_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    rec_next        = rec;
    idx_next        = idx;
    count_next      = count;
    res_status_next = res_status;
    res_rec_next    = res_rec;
    res_last_next   = res_last;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata       = rec;
    mem_raddr       = idx;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next         = in_op;
          rec_next        = in_rec;
          idx_next        = '0;
          res_status_next = ST_OK;
          res_rec_next    = '0;
          res_last_next   = 1'b1;
          if (in_op == OP_ADD && count >= CNT_W'(TABLE_DEPTH)) begin
            res_status_next = ST_FULL;
            state_next      = S_RESULT;
          end else if (count == '0) begin
            // empty table: nothing to search
            case (in_op)
              OP_ADD:  state_next = S_APPEND;
              OP_LIST: state_next = S_RESULT;
              default: begin
                res_status_next = ST_MISSING;
                state_next      = S_RESULT;
              end
            endcase
          end else begin
            state_next = S_RD;
          end
        end
      end

      S_RD: begin
        state_next = S_CMP;
      end

      S_CMP: begin
        if (op == OP_LIST) begin
          res_rec_next    = REC_W'(mem_rdata[KEY_W-1:0]);
          res_last_next   = is_last_entry;
          res_status_next = ST_OK;
          state_next      = S_RESULT;
        end else if (key_hit) begin
          case (op)
            OP_ADD: begin
              res_status_next = ST_DUP;
              state_next      = S_RESULT;
            end
            OP_READ: begin
              res_rec_next    = mem_rdata;
              res_status_next = ST_OK;
              state_next      = S_RESULT;
            end
            default: begin
              state_next = S_SH_RD;
            end
          endcase
        end else if (is_last_entry) begin
          if (op == OP_ADD) begin
            state_next = S_APPEND;
          end else begin
            res_status_next = ST_MISSING;
            state_next      = S_RESULT;
          end
        end else begin
          idx_next   = IDX_W'(idx_inc);
          state_next = S_RD;
        end
      end

      S_APPEND: begin
        mem_we          = 1'b1;
        mem_waddr       = IDX_W'(count);
        mem_wdata       = rec;
        count_next      = count + CNT_W'(1);
        res_status_next = ST_OK;
        state_next      = S_RESULT;
      end

      // move each later entry down by one
      S_SH_RD: begin
        if (idx_inc < count) begin
          mem_raddr  = IDX_W'(idx_inc);
          state_next = S_SH_WR;
        end else begin
          count_next      = count - CNT_W'(1);
          res_status_next = ST_OK;
          state_next      = S_RESULT;
        end
      end

      S_SH_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx;
        mem_wdata  = mem_rdata;
        idx_next   = IDX_W'(idx_inc);
        state_next = S_SH_RD;
      end

      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (op == OP_LIST && !res_last) begin
            idx_next   = IDX_W'(idx_inc);
            state_next = S_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_RD)
    else $error("compare without a preceding read");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_APPEND || state == S_SH_WR))
    else $error("table write outside append or compaction");

  a_shift_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_SH_WR |-> $past(state) == S_SH_RD)
    else $error("compaction write without a preceding read");

endmodule

@@ rtl/keyed_record_table.sv @@
// top level: stream ports, output register, sequencer and record storage
// sequence: a search reads and then compares each entry in turn, an add appends after
//   a miss, a delete moves each later entry down by one, and a list returns one key
//   per result; every request ends in a result handed to the output register
// throughput: one request at a time; the next is taken once the last result of
//   the current one has moved into the output register
// reset: clears entry count and control state; table contents undefined until written
module keyed_record_table #(
  parameter int TABLE_DEPTH = krt_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // key, year, first_course, first_grade, second_course, second_grade,
  // third_course, third_grade
  input  logic [krt_pkg::IN_DATA_W-1:0]     s_tdata,
  // operation
  input  logic [krt_pkg::OP_W-1:0]          s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // used_count, out_key, out_year, out_first_course, out_first_grade,
  // out_second_course, out_second_grade, out_third_course, out_third_grade
  output logic [krt_pkg::OUT_DATA_W-1:0]    m_tdata,
  // status
  output logic [krt_pkg::STATUS_W-1:0]      m_tuser,
  output logic                              m_tlast
);
  import krt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic               res_valid;
  logic               res_ready;
  result_t            res;
  result_t            out_res;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [REC_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [REC_W-1:0]   mem_rdata;

  krt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (op_t'(s_tuser)),
    .in_rec    (s_tdata[REC_W-1:0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  krt_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register frees the sequencer while a result waits downstream
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = OUT_DATA_W'({out_res.rec, out_res.used_count});
  assign m_tuser = out_res.status;
  assign m_tlast = out_res.last;

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> m_tvalid)
    else $error("result transaction lost at output register");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FULL) |-> m_tdata[USED_W-1:0] == USED_W'(TABLE_DEPTH))
    else $error("table full reported below depth");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> m_tdata[OUT_DATA_W-1:USED_W] == '0)
    else $error("record bytes set on a failed request");

endmodule
